### sv/wpfr_pkg.sv
package wpfr_pkg;

    localparam int FRAME_CAPACITY = 32;
    localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);

    localparam int MIN_FRAME  = 7;
    localparam int WAKE_LEN   = 13;
    localparam int PAIR_LEN   = 14;
    localparam int ACK_LEN    = 14;
    localparam int ACK_IDX_W  = $clog2(ACK_LEN);

    localparam logic [7:0] ACK_STATUS = 8'h01;

    localparam int POS_VERSION = 1;
    localparam int POS_COMMAND = 2;
    localparam int POS_HASH_0  = 3;
    localparam int POS_HASH_1  = 4;
    localparam int POS_HASH_2  = 5;
    localparam int POS_HASH_3  = 6;
    localparam int POS_TID_0   = 7;
    localparam int POS_TID_1   = 8;
    localparam int POS_TID_2   = 9;
    localparam int POS_TID_3   = 10;
    localparam int POS_LID     = 11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER     = 3'd0,
        REG_FOOTER     = 3'd1,
        REG_VERSION    = 3'd2,
        REG_WAKE_CMD   = 3'd3,
        REG_PAIR_CMD   = 3'd4,
        REG_ACK_CMD    = 3'd5,
        REG_DEVICE_ID  = 3'd6
    } cfg_index_t;

    localparam logic [7:0]  RST_HEADER    = 8'd165;
    localparam logic [7:0]  RST_FOOTER    = 8'd90;
    localparam logic [7:0]  RST_VERSION   = 8'd2;
    localparam logic [7:0]  RST_WAKE_CMD  = 8'd1;
    localparam logic [7:0]  RST_PAIR_CMD  = 8'd2;
    localparam logic [7:0]  RST_ACK_CMD   = 8'd3;
    localparam logic [31:0] RST_DEVICE_ID = 32'd0;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  footer_byte;
        logic [7:0]  version_byte;
        logic [7:0]  wake_command;
        logic [7:0]  pair_command;
        logic [7:0]  pair_ack_command;
        logic [31:0] device_id;
    } cfg_t;

    typedef struct packed {
        logic        is_pair;
        logic [31:0] hash;
        logic [7:0]  node_lid;
    } job_t;

endpackage

### sv/wpfr_channels.sv
interface wpfr_rx_if;
    import wpfr_pkg::*;

    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface wpfr_res_if;
    import wpfr_pkg::*;

    logic       valid;
    logic       ready;
    logic       event_res;
    logic [7:0] tx_byte;
    logic [7:0] node_logical_id;
    logic       last;

    modport source (output valid, output event_res, output tx_byte,
                    output node_logical_id, output last, input ready);
    modport sink   (input valid, input event_res, input tx_byte,
                    input node_logical_id, input last, output ready);
endinterface

interface wpfr_cfg_if;
    import wpfr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/wpfr_cfg_regs.sv
module wpfr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    wpfr_cfg_if.sink      cfg,
    output wpfr_pkg::cfg_t regs
);
    import wpfr_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_HEADER:    regs_next.header_byte      = cfg.data[7:0];
                REG_FOOTER:    regs_next.footer_byte      = cfg.data[7:0];
                REG_VERSION:   regs_next.version_byte     = cfg.data[7:0];
                REG_WAKE_CMD:  regs_next.wake_command     = cfg.data[7:0];
                REG_PAIR_CMD:  regs_next.pair_command     = cfg.data[7:0];
                REG_ACK_CMD:   regs_next.pair_ack_command = cfg.data[7:0];
                REG_DEVICE_ID: regs_next.device_id        = cfg.data[31:0];
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.header_byte      <= RST_HEADER;
            regs_reg.footer_byte      <= RST_FOOTER;
            regs_reg.version_byte     <= RST_VERSION;
            regs_reg.wake_command     <= RST_WAKE_CMD;
            regs_reg.pair_command     <= RST_PAIR_CMD;
            regs_reg.pair_ack_command <= RST_ACK_CMD;
            regs_reg.device_id        <= RST_DEVICE_ID;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### sv/wpfr_frame_parser.sv
module wpfr_frame_parser (
    input  logic           clk,
    input  logic           rst_n,
    wpfr_rx_if.sink        rx,
    input  wpfr_pkg::cfg_t regs,
    output logic           job_valid,
    output wpfr_pkg::job_t job,
    input  logic           job_take
);
    import wpfr_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       version_reg, version_next;
    logic [7:0]       command_reg, command_next;
    logic [31:0]      hash_reg, hash_next;
    logic [31:0]      tid_reg, tid_next;
    logic [7:0]       lid_reg, lid_next;

    logic             paired_reg, paired_next;
    logic [31:0]      parent_hash_reg, parent_hash_next;
    logic [7:0]       node_lid_reg, node_lid_next;

    logic             job_valid_reg, job_valid_next;
    job_t             job_reg, job_next;

    logic             accept;
    logic             skip;
    logic             close;
    logic [CNT_W-1:0] n;
    logic             cks_ok;
    logic             is_wake_cmd;
    logic             wake_ok;
    logic             pair_ok;

    assign rx.ready  = !job_valid_reg || job_take;
    assign accept    = rx.valid && rx.ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        n           = count_reg + CNT_W'(1);
        skip        = (count_reg == '0) && (rx.rx_byte != regs.header_byte);
        close       = !skip && (rx.rx_byte == regs.footer_byte) && (n >= CNT_W'(MIN_FRAME));
        cks_ok      = (xor_reg == 8'd0);
        is_wake_cmd = (command_reg == regs.wake_command);
        wake_ok     = close && (version_reg == regs.version_byte) && is_wake_cmd
                      && (n >= CNT_W'(WAKE_LEN)) && cks_ok && paired_reg
                      && (hash_reg == parent_hash_reg);
        pair_ok     = close && (version_reg == regs.version_byte) && !is_wake_cmd
                      && (command_reg == regs.pair_command) && (n >= CNT_W'(PAIR_LEN))
                      && cks_ok && (tid_reg == regs.device_id);

        count_next       = count_reg;
        xor_next         = xor_reg;
        version_next     = version_reg;
        command_next     = command_reg;
        hash_next        = hash_reg;
        tid_next         = tid_reg;
        lid_next         = lid_reg;
        paired_next      = paired_reg;
        parent_hash_next = parent_hash_reg;
        node_lid_next    = node_lid_reg;
        job_valid_next   = job_valid_reg && !job_take;
        job_next         = job_reg;

        if (accept)
        begin
            if (rx.kind)
            begin
                count_next = '0;
            end
            else if (!skip)
            begin
                xor_next = (count_reg == '0) ? 8'd0 : (xor_reg ^ rx.rx_byte);
                case (int'(count_reg))
                    POS_VERSION: version_next       = rx.rx_byte;
                    POS_COMMAND: command_next       = rx.rx_byte;
                    POS_HASH_0:  hash_next[31:24]   = rx.rx_byte;
                    POS_HASH_1:  hash_next[23:16]   = rx.rx_byte;
                    POS_HASH_2:  hash_next[15:8]    = rx.rx_byte;
                    POS_HASH_3:  hash_next[7:0]     = rx.rx_byte;
                    POS_TID_0:   tid_next[31:24]    = rx.rx_byte;
                    POS_TID_1:   tid_next[23:16]    = rx.rx_byte;
                    POS_TID_2:   tid_next[15:8]     = rx.rx_byte;
                    POS_TID_3:   tid_next[7:0]      = rx.rx_byte;
                    POS_LID:     lid_next           = rx.rx_byte;
                    default:     lid_next           = lid_reg;
                endcase

                if (close || (n >= CNT_W'(FRAME_CAPACITY)))
                    count_next = '0;
                else
                    count_next = n;

                if (pair_ok)
                begin
                    paired_next      = 1'b1;
                    parent_hash_next = hash_reg;
                    node_lid_next    = lid_reg;
                end

                if (wake_ok || pair_ok)
                begin
                    job_valid_next    = 1'b1;
                    job_next.is_pair  = pair_ok;
                    job_next.hash     = hash_reg;
                    job_next.node_lid = pair_ok ? lid_reg : node_lid_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            paired_reg      <= 1'b0;
            parent_hash_reg <= 32'd0;
            node_lid_reg    <= 8'd0;
            job_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            paired_reg      <= paired_next;
            parent_hash_reg <= parent_hash_next;
            node_lid_reg    <= node_lid_next;
            job_valid_reg   <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xor_reg     <= xor_next;
        version_reg <= version_next;
        command_reg <= command_next;
        hash_reg    <= hash_next;
        tid_reg     <= tid_next;
        lid_reg     <= lid_next;
        job_reg     <= job_next;
    end

endmodule

### sv/wpfr_ack_tx.sv
module wpfr_ack_tx (
    input  logic           clk,
    input  logic           rst_n,
    input  wpfr_pkg::cfg_t regs,
    input  logic           job_valid,
    input  wpfr_pkg::job_t job,
    output logic           job_take,
    wpfr_res_if.source     res
);
    import wpfr_pkg::*;

    logic                 busy_reg, busy_next;
    logic [ACK_IDX_W-1:0] idx_reg, idx_next;
    job_t                 held_reg, held_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_event_reg, out_event_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [7:0]           out_lid_reg, out_lid_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_load;
    logic                 emit;
    job_t                 cur;
    logic [ACK_IDX_W-1:0] cur_idx;
    logic [7:0]           ack_xor;
    logic [7:0]           ack_byte;

    assign res.valid           = out_valid_reg;
    assign res.event_res       = out_event_reg;
    assign res.tx_byte         = out_byte_reg;
    assign res.node_logical_id = out_lid_reg;
    assign res.last            = out_last_reg;

    always_comb
    begin
        out_load = !out_valid_reg || res.ready;
        job_take = out_load && !busy_reg && job_valid;
        emit     = out_load && (busy_reg || job_valid);
        cur      = busy_reg ? held_reg : job;
        cur_idx  = busy_reg ? idx_reg : '0;

        ack_xor = regs.version_byte ^ regs.pair_ack_command
                ^ cur.hash[31:24] ^ cur.hash[23:16] ^ cur.hash[15:8] ^ cur.hash[7:0]
                ^ regs.device_id[31:24] ^ regs.device_id[23:16]
                ^ regs.device_id[15:8] ^ regs.device_id[7:0] ^ ACK_STATUS;

        case (cur_idx)
            4'd0:    ack_byte = regs.header_byte;
            4'd1:    ack_byte = regs.version_byte;
            4'd2:    ack_byte = regs.pair_ack_command;
            4'd3:    ack_byte = cur.hash[31:24];
            4'd4:    ack_byte = cur.hash[23:16];
            4'd5:    ack_byte = cur.hash[15:8];
            4'd6:    ack_byte = cur.hash[7:0];
            4'd7:    ack_byte = regs.device_id[31:24];
            4'd8:    ack_byte = regs.device_id[23:16];
            4'd9:    ack_byte = regs.device_id[15:8];
            4'd10:   ack_byte = regs.device_id[7:0];
            4'd11:   ack_byte = ACK_STATUS;
            4'd12:   ack_byte = ack_xor;
            4'd13:   ack_byte = regs.footer_byte;
            default: ack_byte = 8'd0;
        endcase

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_event_next = out_event_reg;
        out_byte_next  = out_byte_reg;
        out_lid_next   = out_lid_reg;
        out_last_next  = out_last_reg;

        if (job_take)
            held_next = job;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_event_next = cur.is_pair;
            out_byte_next  = cur.is_pair ? ack_byte : 8'd0;
            out_lid_next   = cur.node_lid;
            out_last_next  = !cur.is_pair || (cur_idx == ACK_IDX_W'(ACK_LEN - 1));
            busy_next      = cur.is_pair && (cur_idx != ACK_IDX_W'(ACK_LEN - 1));
            idx_next       = cur_idx + ACK_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        out_event_reg <= out_event_next;
        out_byte_reg  <= out_byte_next;
        out_lid_reg   <= out_lid_next;
        out_last_reg  <= out_last_next;
    end

endmodule

### sv/wake_pair_frame_receiver.sv
// channel  | direction | payload
// rx       | in        | kind, rx_byte
// result   | out       | event_res, tx_byte, node_logical_id, last
// cfg      | in        | index, data (register write, always ready)
//
// one received byte per cycle; a frame decision is registered as the footer is accepted
// a wake result is one byte and an acknowledge 14 bytes on the result port
// rx stalls only while a decided frame waits for the acknowledge sequencer
// result stalls hold the output register; reset returns to unpaired, hunting for a header
module wake_pair_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    wpfr_rx_if.sink    rx,
    wpfr_res_if.source result,
    wpfr_cfg_if.sink   cfg
);
    import wpfr_pkg::*;

    cfg_t regs;
    logic job_valid;
    job_t job;
    logic job_take;

    wpfr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    wpfr_frame_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .regs      (regs),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    wpfr_ack_tx u_ack_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .res       (result)
    );

endmodule

### sim/wake_pair_frame_receiver_tb.sv
`timescale 1ns / 1ps

module wake_pair_frame_receiver_tb;
    import wpfr_pkg::*;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 150;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic       event_res;
        logic [7:0] tx_byte;
        logic [7:0] node_id;
        logic       last;
    } outcome_t;

    typedef enum {
        T_PAIR,
        T_FOREIGN_PAIR,
        T_WAKE,
        T_STRANGER_WAKE,
        T_BAD_SUM,
        T_BAD_VERSION,
        T_BAD_CMD,
        T_SHORT,
        T_OVERLONG,
        T_NOISE,
        T_RESTART
    } traffic_t;

    class pairing_scoreboard;
        cfg_t        regs;
        logic [7:0]  frame_buf [FRAME_CAPACITY];
        int          held;
        bit          paired;
        logic [31:0] parent_hash;
        logic [7:0]  stored_lid;
        outcome_t    due[$];
        int          errors;

        function new();
            regs.header_byte      = RST_HEADER;
            regs.footer_byte      = RST_FOOTER;
            regs.version_byte     = RST_VERSION;
            regs.wake_command     = RST_WAKE_CMD;
            regs.pair_command     = RST_PAIR_CMD;
            regs.pair_ack_command = RST_ACK_CMD;
            regs.device_id        = RST_DEVICE_ID;
            held        = 0;
            paired      = 1'b0;
            parent_hash = '0;
            stored_lid  = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HEADER:    regs.header_byte      = data[7:0];
                REG_FOOTER:    regs.footer_byte      = data[7:0];
                REG_VERSION:   regs.version_byte     = data[7:0];
                REG_WAKE_CMD:  regs.wake_command     = data[7:0];
                REG_PAIR_CMD:  regs.pair_command     = data[7:0];
                REG_ACK_CMD:   regs.pair_ack_command = data[7:0];
                REG_DEVICE_ID: regs.device_id        = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] word_at(int pos);
            return {frame_buf[pos], frame_buf[pos+1], frame_buf[pos+2], frame_buf[pos+3]};
        endfunction

        function bit sum_ok(int n);
            logic [7:0] x;
            x = '0;
            for (int i = 1; i + 2 < n; i++)
                x ^= frame_buf[i];
            return frame_buf[n-2] == x;
        endfunction

        function void push_outcome(logic ev, logic [7:0] tx, logic fin);
            outcome_t o;
            o.event_res = ev;
            o.tx_byte   = tx;
            o.node_id   = stored_lid;
            o.last      = fin;
            due.push_back(o);
        endfunction

        function void close_frame(int n);
            logic [7:0]  ack [PAIR_LEN];
            logic [7:0]  x;
            logic [7:0]  cmd;
            logic [31:0] hash;
            cmd = frame_buf[POS_COMMAND];
            if (frame_buf[POS_VERSION] != regs.version_byte)
                return;
            if (cmd == regs.wake_command)
            begin
                if (n >= WAKE_LEN && sum_ok(n) && paired &&
                    word_at(POS_HASH_0) == parent_hash)
                    push_outcome(1'b0, 8'h00, 1'b1);
                return;
            end
            if (cmd != regs.pair_command || n < PAIR_LEN)
                return;
            if (!sum_ok(n) || word_at(POS_TID_0) != regs.device_id)
                return;
            hash        = word_at(POS_HASH_0);
            parent_hash = hash;
            stored_lid  = frame_buf[POS_LID];
            paired      = 1'b1;
            ack[0] = regs.header_byte;
            ack[1] = regs.version_byte;
            ack[2] = regs.pair_ack_command;
            for (int i = 0; i < 4; i++)
            begin
                ack[3+i] = hash[31-8*i -: 8];
                ack[7+i] = regs.device_id[31-8*i -: 8];
            end
            ack[11] = ACK_STATUS;
            x = '0;
            for (int i = 1; i < 12; i++)
                x ^= ack[i];
            ack[12] = x;
            ack[13] = regs.footer_byte;
            for (int i = 0; i < PAIR_LEN; i++)
                push_outcome(1'b1, ack[i], i == PAIR_LEN - 1);
        endfunction

        // returns 1 when the transaction touched the frame state
        function bit take_rx_item(logic kind, logic [7:0] b);
            if (kind == KIND_RESTART)
            begin
                held = 0;
                return 1'b1;
            end
            if (held == 0 && b != regs.header_byte)
                return 1'b0;
            if (held < FRAME_CAPACITY)
                frame_buf[held] = b;
            held++;
            if (b == regs.footer_byte && held >= MIN_FRAME)
            begin
                close_frame(held);
                held = 0;
            end
            if (held >= FRAME_CAPACITY)
                held = 0;
            return 1'b1;
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: event %0d tx %h id %h last %0d",
                             got.event_res, got.tx_byte, got.node_id, got.last);
                return;
            end
            want = due.pop_front();
            if (got.event_res !== want.event_res || got.tx_byte !== want.tx_byte ||
                got.node_id !== want.node_id || got.last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("result mismatch: expected event %0d tx %h id %h last %0d",
                             want.event_res, want.tx_byte, want.node_id, want.last);
                    $display("                 got event %0d tx %h id %h last %0d",
                             got.event_res, got.tx_byte, got.node_id, got.last);
                end
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wpfr_rx_if  rx ();
    wpfr_res_if result ();
    wpfr_cfg_if cfg ();

    wake_pair_frame_receiver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .result (result),
        .cfg    (cfg)
    );

    pairing_scoreboard sb = new();

    bit         no_idling = 1'b0;
    int         hold_ask = 0;
    int         items_sent = 0;
    int         dead_cycles = 0;
    logic [7:0] frame_q[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver side: random stalls, calm stretches and the long hold-off
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left   = 0;
        calm_left    = 0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ask > 0)
            begin
                stall_left = hold_ask;
                hold_ask   = 0;
            end
            if (stall_left > 0)
            begin
                result.ready = 1'b0;
                stall_left--;
            end
            else if (no_idling || calm_left > 0)
            begin
                result.ready = 1'b1;
                if (calm_left > 0)
                    calm_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                result.ready = 1'b0;
                stall_left   = $urandom_range(1, 10) - 1;
            end
            else
            begin
                result.ready = 1'b1;
                if ($urandom_range(0, 15) == 0)
                    calm_left = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t got;
        if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
        begin
            got.event_res = result.event_res;
            got.tx_byte   = result.tx_byte;
            got.node_id   = result.node_logical_id;
            got.last      = result.last;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((rx.valid === 1'b1 && rx.ready === 1'b1) ||
            (result.valid === 1'b1 && result.ready === 1'b1) ||
            (cfg.valid === 1'b1 && cfg.ready === 1'b1))
            dead_cycles = 0;
        else
            dead_cycles++;
        if (dead_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL wake_pair_frame_receiver");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] value, input bit gaps);
        @(negedge clk);
        if (gaps && !no_idling && $urandom_range(0, 5) == 0)
        begin
            rx.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        rx.valid   = 1'b1;
        rx.kind    = kind;
        rx.rx_byte = value;
        do @(posedge clk); while (rx.ready !== 1'b1);
        if (sb.take_rx_item(kind, value))
            items_sent++;
    endtask

    task automatic send_frame(input bit gaps);
        foreach (frame_q[i])
            send_item(KIND_BYTE, frame_q[i], gaps);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        rx.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // upper data bits of a byte register carry junk
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [7:0] v);
        logic [CFG_DATA_W-1:0] w;
        w      = $urandom;
        w[7:0] = v;
        return w;
    endfunction

    task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] ftr,
                                  input logic [7:0] ver, input logic [7:0] wake,
                                  input logic [7:0] pair, input logic [7:0] ack,
                                  input logic [31:0] dev);
        write_reg(REG_HEADER, with_junk(hdr));
        write_reg(REG_FOOTER, with_junk(ftr));
        write_reg(REG_VERSION, with_junk(ver));
        write_reg(REG_WAKE_CMD, with_junk(wake));
        write_reg(REG_PAIR_CMD, with_junk(pair));
        write_reg(REG_ACK_CMD, with_junk(ack));
        write_reg(REG_DEVICE_ID, dev);
    endtask

    task automatic random_settings(input bit same_cmd);
        logic [7:0]  hdr;
        logic [7:0]  ftr;
        logic [7:0]  wake;
        logic [7:0]  pair;
        logic [31:0] dev;
        hdr = 8'($urandom);
        do ftr = 8'($urandom); while (ftr == hdr);
        wake = 8'($urandom);
        if (same_cmd)
            pair = wake;
        else
            do pair = 8'($urandom); while (pair == wake);
        do dev = $urandom;
        while (dev[31:24] == ftr || dev[23:16] == ftr || dev[15:8] == ftr || dev[7:0] == ftr);
        apply_settings(hdr, ftr, 8'($urandom), wake, pair, 8'($urandom), dev);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == sb.regs.footer_byte);
        return b;
    endfunction

    // the low hash byte sits where a footer would close the frame early
    function automatic logic [31:0] rand_hash();
        logic [31:0] h;
        h = $urandom;
        if (h[7:0] == sb.regs.footer_byte)
            h[7:0] = ~h[7:0];
        return h;
    endfunction

    function automatic void compose_frame(logic [7:0] ver, logic [7:0] cmd, logic [31:0] hash,
                                          bit as_pair, logic [31:0] tid, logic [7:0] lid,
                                          int pad, bit spoil);
        logic [7:0] x;
        logic [7:0] fix;
        frame_q = {};
        frame_q.push_back(sb.regs.header_byte);
        frame_q.push_back(ver);
        frame_q.push_back(cmd);
        for (int i = 3; i >= 0; i--)
            frame_q.push_back(hash[8*i +: 8]);
        if (as_pair)
        begin
            for (int i = 3; i >= 0; i--)
                frame_q.push_back(tid[8*i +: 8]);
            frame_q.push_back(lid);
        end
        else
            repeat (4) frame_q.push_back(plain_byte());
        repeat (pad) frame_q.push_back(plain_byte());
        x = '0;
        for (int i = 1; i < frame_q.size(); i++)
            x ^= frame_q[i];
        if (spoil)
        begin
            do fix = 8'($urandom_range(1, 255)); while ((x ^ fix) == sb.regs.footer_byte);
            x ^= fix;
        end
        else if (x == sb.regs.footer_byte)
        begin
            // checksum would read as a footer, so stretch the frame by one byte
            do fix = 8'($urandom_range(1, 255)); while (fix == sb.regs.footer_byte);
            frame_q.push_back(fix);
            x ^= fix;
        end
        frame_q.push_back(x);
        frame_q.push_back(sb.regs.footer_byte);
    endfunction

    function automatic traffic_t pick_traffic();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 16)      return T_PAIR;
        else if (roll < 40) return T_WAKE;
        else if (roll < 47) return T_STRANGER_WAKE;
        else if (roll < 54) return T_FOREIGN_PAIR;
        else if (roll < 62) return T_BAD_SUM;
        else if (roll < 68) return T_BAD_VERSION;
        else if (roll < 74) return T_BAD_CMD;
        else if (roll < 80) return T_SHORT;
        else if (roll < 84) return T_OVERLONG;
        else if (roll < 91) return T_NOISE;
        else                return T_RESTART;
    endfunction

    function automatic logic [7:0] other_cmd();
        logic [7:0] c;
        do c = 8'($urandom);
        while (c == sb.regs.wake_command || c == sb.regs.pair_command);
        return c;
    endfunction

    task automatic random_traffic(input int target);
        traffic_t    pick;
        bit          gaps;
        bit          as_pair;
        int          pad;
        int          n;
        int          cut;
        logic [7:0]  ver;
        logic [7:0]  cmd;
        logic [31:0] dev;
        logic [31:0] tid;
        while (items_sent < target)
        begin
            gaps    = $urandom_range(0, 4) != 0;
            pick    = pick_traffic();
            as_pair = $urandom_range(0, 1);
            pad     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            ver     = sb.regs.version_byte;
            dev     = sb.regs.device_id;
            cmd     = as_pair ? sb.regs.pair_command : sb.regs.wake_command;
            if (pick == T_WAKE && !sb.paired)
                pick = T_STRANGER_WAKE;
            case (pick)
                T_PAIR:
                begin
                    compose_frame(ver, sb.regs.pair_command, rand_hash(), 1'b1, dev,
                                  plain_byte(), pad, 1'b0);
                    send_frame(gaps);
                end
                T_FOREIGN_PAIR:
                begin
                    do tid = {plain_byte(), plain_byte(), plain_byte(), plain_byte()};
                    while (tid == dev);
                    compose_frame(ver, sb.regs.pair_command, rand_hash(), 1'b1, tid,
                                  plain_byte(), pad, 1'b0);
                    send_frame(gaps);
                end
                T_WAKE:
                begin
                    compose_frame(ver, sb.regs.wake_command, sb.parent_hash, 1'b0, '0, '0,
                                  pad, 1'b0);
                    send_frame(gaps);
                end
                T_STRANGER_WAKE:
                begin
                    compose_frame(ver, sb.regs.wake_command, rand_hash(), 1'b0, '0, '0,
                                  pad, 1'b0);
                    send_frame(gaps);
                end
                T_BAD_SUM:
                begin
                    compose_frame(ver, cmd, as_pair ? rand_hash() : sb.parent_hash, as_pair,
                                  dev, plain_byte(), pad, 1'b1);
                    send_frame(gaps);
                end
                T_BAD_VERSION:
                begin
                    compose_frame(ver ^ 8'($urandom_range(1, 255)), cmd,
                                  as_pair ? rand_hash() : sb.parent_hash, as_pair, dev,
                                  plain_byte(), pad, 1'b0);
                    send_frame(gaps);
                end
                T_BAD_CMD:
                begin
                    compose_frame(ver, other_cmd(), rand_hash(), as_pair, dev, plain_byte(),
                                  pad, 1'b0);
                    send_frame(gaps);
                end
                T_SHORT:
                begin
                    n = $urandom_range(MIN_FRAME, as_pair ? PAIR_LEN - 1 : WAKE_LEN - 1);
                    frame_q = {sb.regs.header_byte, ver, cmd};
                    while (frame_q.size() < n - 1)
                        frame_q.push_back(plain_byte());
                    frame_q.push_back(sb.regs.footer_byte);
                    send_frame(gaps);
                end
                T_OVERLONG:
                begin
                    frame_q = {sb.regs.header_byte};
                    repeat ($urandom_range(FRAME_CAPACITY - 1, FRAME_CAPACITY + 4))
                        frame_q.push_back(plain_byte());
                    send_frame(gaps);
                end
                T_NOISE:
                begin
                    repeat ($urandom_range(1, 6))
                        send_item(KIND_BYTE, 8'($urandom), gaps);
                end
                T_RESTART:
                begin
                    compose_frame(ver, cmd, as_pair ? rand_hash() : sb.parent_hash, as_pair,
                                  dev, plain_byte(), pad, 1'b0);
                    cut = $urandom_range(1, frame_q.size() - 1);
                    for (int i = 0; i < cut; i++)
                        send_item(KIND_BYTE, frame_q[i], gaps);
                    send_item(KIND_RESTART, 8'($urandom), gaps);
                    if ($urandom_range(0, 1))
                        for (int i = cut; i < frame_q.size(); i++)
                            send_item(KIND_BYTE, frame_q[i], gaps);
                end
                default: ;
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx.valid      = 1'b0;
        rx.kind       = KIND_BYTE;
        rx.rx_byte    = 8'h00;
        cfg.valid     = 1'b0;
        cfg.index     = REG_HEADER;
        cfg.data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: stray bytes, restart, wake before pairing, then pairing
        send_item(KIND_BYTE, 8'h00, 1'b0);
        send_item(KIND_BYTE, 8'hFF, 1'b0);
        send_item(KIND_RESTART, sb.regs.header_byte, 1'b0);
        compose_frame(sb.regs.version_byte, sb.regs.wake_command, 32'h0000_0000, 1'b0,
                      '0, '0, 0, 1'b0);
        send_frame(1'b0);
        compose_frame(sb.regs.version_byte, sb.regs.pair_command, 32'h00FF_00FF, 1'b1,
                      sb.regs.device_id, 8'hFF, 0, 1'b0);
        send_frame(1'b0);
        wait_drained();

        apply_settings(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, $urandom);
        // long receiver hold-off while acknowledges pile up
        hold_ask = HOLD_CYCLES;
        repeat (2)
        begin
            compose_frame(sb.regs.version_byte, sb.regs.pair_command, rand_hash(), 1'b1,
                          sb.regs.device_id, plain_byte(), 0, 1'b0);
            send_frame(1'b0);
        end
        compose_frame(sb.regs.version_byte, sb.regs.wake_command, sb.parent_hash, 1'b0,
                      '0, '0, 0, 1'b0);
        send_frame(1'b0);
        random_traffic(90);
        wait_drained();

        apply_settings(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 32'h0000_0000);
        random_traffic(150);
        wait_drained();

        random_settings(1'b0);
        random_traffic(210);
        wait_drained();

        // wake and pair share one command code
        random_settings(1'b1);
        random_traffic(260);
        wait_drained();

        no_idling = 1'b1;
        random_settings(1'b0);
        random_traffic(320);
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS wake_pair_frame_receiver");
        else
            $display("FAIL wake_pair_frame_receiver");
        $finish;
    end

endmodule
